// ===== design/bpt_pkg.sv =====
// Shared types, register indexes, reset values and the xorshift step
// for the bouncing polygon trail engine. No dependencies.
package bpt_pkg;

    // default sizes handed to the top level
    localparam int MAX_POLYS_DEF  = 16;
    localparam int MAX_VERTS_DEF  = 32;
    localparam int MAX_TRAIL_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_POLYGON_COUNT = 3'd2;
    localparam logic [2:0] REG_POINT_COUNT   = 3'd3;
    localparam logic [2:0] REG_TRAIL_LENGTH  = 3'd4;
    localparam logic [2:0] REG_MAX_SPEED     = 3'd5;
    localparam logic [2:0] REG_COLOR_COUNT   = 3'd6;
    localparam logic [2:0] REG_RNG_SEED      = 3'd7;

    // register reset values
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [4:0]  RST_POLYGON_COUNT = 5'd2;
    localparam logic [5:0]  RST_POINT_COUNT   = 6'd4;
    localparam logic [6:0]  RST_TRAIL_LENGTH  = 7'd5;
    localparam logic [7:0]  RST_MAX_SPEED     = 8'd14;
    localparam logic [8:0]  RST_COLOR_COUNT   = 9'd64;
    localparam logic [31:0] RST_RNG_SEED      = 32'd1;

    // request modes
    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_BUILD  = 2'd1;
    localparam logic [1:0] MODE_RESEED = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [31:0] XS_ZERO_FIX = 32'h6d2b79f5;
    // reciprocal of 6 in 10 fractional bits, exact for speeds up to 128
    localparam logic [15:0] SIXTH_MUL = 16'd171;
    localparam int          SIXTH_SHIFT = 10;

    // configuration after saturation, as the sequencer sees it
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] x_top;
        logic [15:0] y_top;
        logic [6:0]  polys;
        logic [6:0]  verts;
        logic [8:0]  slots;
        logic [7:0]  speed_lo;
        logic [7:0]  speed_span;
        logic [8:0]  colors;
        logic [31:0] seed;
    } cfg_t;

    // one result
    typedef struct packed {
        logic [4:0]  vertex;
        logic [11:0] draw_x;
        logic [11:0] draw_y;
        logic        erase_valid;
        logic [11:0] erase_x;
        logic [11:0] erase_y;
        logic [7:0]  color;
        logic        last;
    } result_t;

    function automatic logic [31:0] xs32(input logic [31:0] s);
        logic [31:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return (x == 32'd0) ? XS_ZERO_FIX : x;
    endfunction

endpackage

// ===== design/bpt_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Gives quotient and remainder; no package dependencies.
module bpt_div #(
    parameter int DVW = 13
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     dividend,
    input  logic [DVW-1:0]  divisor,
    output logic            done,
    output logic [31:0]     quotient,
    output logic [DVW-1:0]  remainder
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [31:0]    quo_reg, quo_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] den_reg, den_next;
    logic [DVW:0]   trial;
    logic           fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVW'(trial - {1'b0, den_reg}) : DVW'(trial);
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/bpt_core.sv =====
// Sequencer of the polygon engine: trail and velocity memories, per-polygon
// ring and color state, the generator and one shared move unit.
// Depends on bpt_pkg and bpt_div.
module bpt_core #(
    parameter int MAX_POLYS  = bpt_pkg::MAX_POLYS_DEF,
    parameter int MAX_VERTS  = bpt_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRAIL  = bpt_pkg::MAX_TRAIL_DEF,
    parameter int COORD_BITS = bpt_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bpt_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_mode,
    input  logic [3:0]       in_poly,
    output logic             out_valid,
    input  logic             out_ready,
    output bpt_pkg::result_t out_data
);

    localparam int CB    = COORD_BITS;
    localparam int PW    = (MAX_POLYS > 1) ? $clog2(MAX_POLYS) : 1;
    localparam int VW    = $clog2(MAX_VERTS);
    localparam int SLOTS = MAX_TRAIL + 1;
    localparam int SLW   = $clog2(MAX_TRAIL + 2);
    localparam int TD    = MAX_POLYS * SLOTS * MAX_VERTS;
    localparam int TAW   = $clog2(TD);
    localparam int VD    = MAX_POLYS * MAX_VERTS;
    localparam int VAW   = $clog2(VD);
    localparam int DVW   = (CB + 1 > 10) ? CB + 1 : 10;
    localparam int MW    = (CB + 3 > 10) ? CB + 3 : 10;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DRAW     = 5'd1;
    localparam logic [4:0] S_DWAIT    = 5'd2;
    localparam logic [4:0] S_SPD_A    = 5'd3;
    localparam logic [4:0] S_SPD_B    = 5'd4;
    localparam logic [4:0] S_SPD_C    = 5'd5;
    localparam logic [4:0] S_RB_POLY  = 5'd6;
    localparam logic [4:0] S_RB_COL   = 5'd7;
    localparam logic [4:0] S_RB_V0    = 5'd8;
    localparam logic [4:0] S_RB_V1    = 5'd9;
    localparam logic [4:0] S_RB_V2    = 5'd10;
    localparam logic [4:0] S_RB_V3    = 5'd11;
    localparam logic [4:0] S_RB_V4    = 5'd12;
    localparam logic [4:0] S_RB_V5    = 5'd13;
    localparam logic [4:0] S_RB_V6    = 5'd14;
    localparam logic [4:0] S_RB_FILL  = 5'd15;
    localparam logic [4:0] S_ST_HEAD  = 5'd16;
    localparam logic [4:0] S_ST_HWAIT = 5'd17;
    localparam logic [4:0] S_SV_RD0   = 5'd18;
    localparam logic [4:0] S_SV_RD1   = 5'd19;
    localparam logic [4:0] S_SV_RD2   = 5'd20;
    localparam logic [4:0] S_SV_MX    = 5'd21;
    localparam logic [4:0] S_SV_MX2   = 5'd22;
    localparam logic [4:0] S_SV_MY    = 5'd23;
    localparam logic [4:0] S_SV_MY2   = 5'd24;
    localparam logic [4:0] S_SV_WR    = 5'd25;

    logic [4:0]        state_reg, state_next;
    logic [4:0]        ret_reg, ret_next;
    logic [4:0]        sret_reg, sret_next;
    logic [31:0]       rng_reg, rng_next;
    logic [PW-1:0]     poly_reg, poly_next;
    logic [VW-1:0]     vert_reg, vert_next;
    logic [SLW-1:0]    slot_reg, slot_next;
    logic [SLW-1:0]    head_reg, head_next;
    logic [SLW-1:0]    nxt_reg, nxt_next;
    logic              erase_reg, erase_next;
    logic [7:0]        col_reg, col_next;
    logic [DVW-1:0]    dtop_reg, dtop_next;
    logic              raw_reg, raw_next;
    logic [DVW-1:0]    dres_reg, dres_next;
    logic [7:0]        a_reg, a_next;
    logic [7:0]        m_reg, m_next;
    logic [CB-1:0]     px_reg, px_next;
    logic [CB-1:0]     py_reg, py_next;
    logic [CB-1:0]     nx_reg, nx_next;
    logic [CB-1:0]     ny_reg, ny_next;
    logic [CB-1:0]     ex_reg, ex_next;
    logic [CB-1:0]     ey_reg, ey_next;
    logic signed [8:0] vx_reg, vx_next;
    logic signed [8:0] vy_reg, vy_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    bpt_pkg::result_t  out_reg, out_next;

    logic [SLW-1:0]    ring_head_reg [MAX_POLYS];
    logic [SLW-1:0]    ring_fill_reg [MAX_POLYS];
    logic [7:0]        cpos_reg [MAX_POLYS];
    logic              cdir_reg [MAX_POLYS];

    logic [2*CB-1:0]   trail_mem [TD];
    logic [17:0]       vel_mem [VD];
    logic [2*CB-1:0]   tr_rdata;
    logic [17:0]       vel_rdata;
    logic              tr_we, vel_we;
    logic [SLW-1:0]    slot_sel;
    logic [TAW-1:0]    tr_addr;
    logic [VAW-1:0]    vel_addr;
    logic [2*CB-1:0]   tr_wdata;

    logic              col_init, col_step, ring_adv;
    logic              div_start, div_done;
    logic [31:0]       div_dividend, div_quo;
    logic [DVW-1:0]    div_divisor, div_rem;
    logic [31:0]       rng_step;
    logic [SLW-1:0]    ns_l;
    logic [SLW-1:0]    head_inc;
    logic signed [9:0] col_try;
    logic [7:0]        col_new;
    logic [8:0]        ab_sum;
    logic [7:0]        m_calc;
    logic signed [8:0] m_pos;

    logic              mv_sel, mv_neg, mv_over, mv_tiny;
    logic signed [MW-1:0] mv_pos, mv_vel, mv_lim, mv_sum, mv_ref, mv_clip;
    logic [CB-1:0]     mv_res;

    bpt_div #(.DVW(DVW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // shared move unit: one axis per cycle, chosen by state
    always_comb
    begin
        mv_sel  = (state_reg == S_SV_MY);
        mv_pos  = $signed({{(MW-CB){1'b0}}, (mv_sel ? py_reg : px_reg)});
        mv_vel  = mv_sel ? $signed({{(MW-9){vy_reg[8]}}, vy_reg})
                         : $signed({{(MW-9){vx_reg[8]}}, vx_reg});
        mv_lim  = $signed(MW'(mv_sel ? cfg.height : cfg.width));
        mv_tiny = mv_lim <= $signed(MW'(1));
        mv_sum  = mv_pos + mv_vel;
        mv_neg  = mv_sum < $signed(MW'(0));
        mv_over = !mv_neg && (mv_sum >= mv_lim);
        if (mv_neg)
            mv_ref = -mv_sum;
        else if (mv_over)
            mv_ref = (mv_lim - $signed(MW'(1))) + (mv_lim - $signed(MW'(1))) - mv_sum;
        else
            mv_ref = mv_sum;
        if (mv_ref < $signed(MW'(0)))
            mv_clip = '0;
        else if (mv_ref > mv_lim - $signed(MW'(1)))
            mv_clip = mv_lim - $signed(MW'(1));
        else
            mv_clip = mv_ref;
        mv_res = mv_clip[CB-1:0];
    end

    always_comb
    begin
        rng_step = bpt_pkg::xs32(rng_reg);
        ns_l     = SLW'(cfg.slots);
        head_inc = SLW'(div_rem) + SLW'(1);
        col_try  = $signed({2'b00, cpos_reg[poly_reg]})
                 + (cdir_reg[poly_reg] ? 10'sd1 : -10'sd1);
        if (col_try < 10'sd0)
            col_new = 8'(cfg.colors - 9'd1);
        else if (col_try >= $signed({1'b0, cfg.colors}))
            col_new = 8'd0;
        else
            col_new = col_try[7:0];
        ab_sum   = 9'(a_reg) + 9'(dres_reg[7:0]);
        m_calc   = cfg.speed_lo + ab_sum[8:1];
        m_pos    = $signed({1'b0, m_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        sret_next      = sret_reg;
        rng_next       = rng_reg;
        poly_next      = poly_reg;
        vert_next      = vert_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        nxt_next       = nxt_reg;
        erase_next     = erase_reg;
        col_next       = col_reg;
        dtop_next      = dtop_reg;
        raw_next       = raw_reg;
        dres_next      = dres_reg;
        a_next         = a_reg;
        m_next         = m_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        div_dividend   = rng_step;
        div_divisor    = dtop_reg + DVW'(1);
        tr_we          = 1'b0;
        vel_we         = 1'b0;
        slot_sel       = nxt_reg;
        tr_wdata       = {ny_reg, nx_reg};
        col_init       = 1'b0;
        col_step       = 1'b0;
        ring_adv       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode)
                        bpt_pkg::MODE_STEP:
                        begin
                            if ({3'b000, in_poly} < cfg.polys)
                            begin
                                poly_next  = PW'(in_poly);
                                state_next = S_ST_HEAD;
                            end
                        end
                        bpt_pkg::MODE_BUILD:
                        begin
                            poly_next  = '0;
                            state_next = S_RB_POLY;
                        end
                        bpt_pkg::MODE_RESEED:
                        begin
                            rng_next   = (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
                            poly_next  = '0;
                            state_next = S_RB_POLY;
                        end
                        default: ;
                    endcase
                end
            end
            // one random draw: raw bit, or uniform in [0, dtop]
            S_DRAW:
            begin
                if (raw_reg)
                begin
                    rng_next   = rng_step;
                    dres_next  = DVW'(rng_step[0]);
                    state_next = ret_reg;
                end
                else if (dtop_reg == '0)
                begin
                    dres_next  = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    rng_next   = rng_step;
                    div_start  = 1'b1;
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    dres_next  = div_rem;
                    state_next = ret_reg;
                end
            end
            S_SPD_A:
            begin
                dtop_next  = DVW'(cfg.speed_span);
                raw_next   = 1'b0;
                ret_next   = S_SPD_B;
                state_next = S_DRAW;
            end
            S_SPD_B:
            begin
                a_next     = dres_reg[7:0];
                ret_next   = S_SPD_C;
                state_next = S_DRAW;
            end
            S_SPD_C:
            begin
                m_next     = m_calc;
                state_next = sret_reg;
            end
            S_RB_POLY:
            begin
                div_start    = 1'b1;
                div_dividend = 32'(16'(poly_reg) * 16'(cfg.colors));
                div_divisor  = DVW'(cfg.polys);
                state_next   = S_RB_COL;
            end
            S_RB_COL:
            begin
                if (div_done)
                begin
                    col_init   = 1'b1;
                    vert_next  = '0;
                    state_next = S_RB_V0;
                end
            end
            S_RB_V0:
            begin
                dtop_next  = DVW'(cfg.x_top);
                raw_next   = 1'b0;
                ret_next   = S_RB_V1;
                state_next = S_DRAW;
            end
            S_RB_V1:
            begin
                px_next    = CB'(dres_reg);
                dtop_next  = DVW'(cfg.y_top);
                raw_next   = 1'b0;
                ret_next   = S_RB_V2;
                state_next = S_DRAW;
            end
            S_RB_V2:
            begin
                py_next    = CB'(dres_reg);
                sret_next  = S_RB_V3;
                state_next = S_SPD_A;
            end
            S_RB_V3:
            begin
                raw_next   = 1'b1;
                ret_next   = S_RB_V4;
                state_next = S_DRAW;
            end
            S_RB_V4:
            begin
                vx_next    = dres_reg[0] ? m_pos : -m_pos;
                sret_next  = S_RB_V5;
                state_next = S_SPD_A;
            end
            S_RB_V5:
            begin
                raw_next   = 1'b1;
                ret_next   = S_RB_V6;
                state_next = S_DRAW;
            end
            S_RB_V6:
            begin
                vy_next    = dres_reg[0] ? m_pos : -m_pos;
                slot_next  = '0;
                state_next = S_RB_FILL;
            end
            // copy the start position into every ring slot
            S_RB_FILL:
            begin
                slot_sel  = slot_reg;
                tr_wdata  = {py_reg, px_reg};
                tr_we     = 1'b1;
                vel_we    = (slot_reg == '0);
                slot_next = slot_reg + SLW'(1);
                if (9'(slot_reg) == cfg.slots - 9'd1)
                begin
                    if (7'(vert_reg) == cfg.verts - 7'd1)
                    begin
                        if (7'(poly_reg) == cfg.polys - 7'd1)
                            state_next = S_IDLE;
                        else
                        begin
                            poly_next  = poly_reg + PW'(1);
                            state_next = S_RB_POLY;
                        end
                    end
                    else
                    begin
                        vert_next  = vert_reg + VW'(1);
                        state_next = S_RB_V0;
                    end
                end
            end
            S_ST_HEAD:
            begin
                div_start    = 1'b1;
                div_dividend = 32'(ring_head_reg[poly_reg]);
                div_divisor  = DVW'(cfg.slots);
                state_next   = S_ST_HWAIT;
            end
            S_ST_HWAIT:
            begin
                if (div_done)
                begin
                    head_next  = SLW'(div_rem);
                    nxt_next   = (head_inc == ns_l) ? '0 : head_inc;
                    erase_next = ring_fill_reg[poly_reg] >= ns_l;
                    col_next   = col_new;
                    col_step   = 1'b1;
                    vert_next  = '0;
                    state_next = S_SV_RD0;
                end
            end
            S_SV_RD0:
            begin
                slot_sel   = head_reg;
                state_next = S_SV_RD1;
            end
            S_SV_RD1:
            begin
                px_next    = tr_rdata[CB-1:0];
                py_next    = tr_rdata[2*CB-1:CB];
                vx_next    = $signed(vel_rdata[8:0]);
                vy_next    = $signed(vel_rdata[17:9]);
                state_next = S_SV_RD2;
            end
            S_SV_RD2:
            begin
                ex_next    = erase_reg ? tr_rdata[CB-1:0] : '0;
                ey_next    = erase_reg ? tr_rdata[2*CB-1:CB] : '0;
                state_next = S_SV_MX;
            end
            S_SV_MX:
            begin
                if (mv_tiny)
                begin
                    nx_next    = '0;
                    vx_next    = '0;
                    state_next = S_SV_MY;
                end
                else
                begin
                    nx_next = mv_res;
                    if (mv_neg || mv_over)
                    begin
                        neg_next   = mv_over;
                        sret_next  = S_SV_MX2;
                        state_next = S_SPD_A;
                    end
                    else
                        state_next = S_SV_MY;
                end
            end
            S_SV_MX2:
            begin
                vx_next    = neg_reg ? -m_pos : m_pos;
                state_next = S_SV_MY;
            end
            S_SV_MY:
            begin
                if (mv_tiny)
                begin
                    ny_next    = '0;
                    vy_next    = '0;
                    state_next = S_SV_WR;
                end
                else
                begin
                    ny_next = mv_res;
                    if (mv_neg || mv_over)
                    begin
                        neg_next   = mv_over;
                        sret_next  = S_SV_MY2;
                        state_next = S_SPD_A;
                    end
                    else
                        state_next = S_SV_WR;
                end
            end
            S_SV_MY2:
            begin
                vy_next    = neg_reg ? -m_pos : m_pos;
                state_next = S_SV_WR;
            end
            // hold until the output register is free
            S_SV_WR:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    tr_we                = 1'b1;
                    vel_we               = 1'b1;
                    out_valid_next       = 1'b1;
                    out_next.vertex      = 5'(vert_reg);
                    out_next.draw_x      = 12'(nx_reg);
                    out_next.draw_y      = 12'(ny_reg);
                    out_next.erase_valid = erase_reg;
                    out_next.erase_x     = 12'(ex_reg);
                    out_next.erase_y     = 12'(ey_reg);
                    out_next.color       = col_reg;
                    out_next.last        = (7'(vert_reg) == cfg.verts - 7'd1);
                    if (7'(vert_reg) == cfg.verts - 7'd1)
                    begin
                        ring_adv   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        vert_next  = vert_reg + VW'(1);
                        state_next = S_SV_RD0;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign tr_addr  = TAW'((int'(poly_reg) * SLOTS + int'(slot_sel)) * MAX_VERTS
                           + int'(vert_reg));
    assign vel_addr = VAW'(int'(poly_reg) * MAX_VERTS + int'(vert_reg));

    always_ff @(posedge clk)
    begin
        if (tr_we)
            trail_mem[tr_addr] <= tr_wdata;
        tr_rdata <= trail_mem[tr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
            vel_mem[vel_addr] <= {vy_reg, vx_reg};
        vel_rdata <= vel_mem[vel_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POLYS; i++)
            begin
                ring_head_reg[i] <= '0;
                ring_fill_reg[i] <= SLW'(1);
                cpos_reg[i]      <= '0;
                cdir_reg[i]      <= 1'b0;
            end
        end
        else
        begin
            if (col_init)
            begin
                ring_head_reg[poly_reg] <= '0;
                ring_fill_reg[poly_reg] <= SLW'(1);
                cpos_reg[poly_reg]      <= div_quo[7:0];
                cdir_reg[poly_reg]      <= poly_reg[0];
            end
            if (col_step)
                cpos_reg[poly_reg] <= col_new;
            if (ring_adv)
            begin
                ring_head_reg[poly_reg] <= nxt_reg;
                ring_fill_reg[poly_reg] <= (ring_fill_reg[poly_reg] < ns_l)
                                         ? ring_fill_reg[poly_reg] + SLW'(1) : ns_l;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            sret_reg      <= S_IDLE;
            rng_reg       <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            sret_reg      <= sret_next;
            rng_reg       <= rng_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poly_reg  <= poly_next;
        vert_reg  <= vert_next;
        slot_reg  <= slot_next;
        head_reg  <= head_next;
        nxt_reg   <= nxt_next;
        erase_reg <= erase_next;
        col_reg   <= col_next;
        dtop_reg  <= dtop_next;
        raw_reg   <= raw_next;
        dres_reg  <= dres_next;
        a_reg     <= a_next;
        m_reg     <= m_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        neg_reg   <= neg_next;
        out_reg   <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/bouncing_polygon_trail_step.sv =====
// Top level of the bouncing polygon trail engine: configuration registers,
// their saturation, and the stream ports. Depends on bpt_pkg and bpt_core.
//
//   channel   | direction | contents
//   ----------+-----------+------------------------------------------------
//   cfg_*     | in        | register write: index, data (no read-back)
//   s_axis_*  | in        | request: tuser mode, tdata polygon
//   m_axis_*  | out       | one result per vertex, tlast on the final vertex
//
// A step request does a head lookup in the divider and then works through
// each vertex; each wall bounce adds up to two divider passes.
// A rebuild takes, per vertex, up to six divider passes plus a ring fill
// of trail_length+1 slots; all passes use the shared divider.
// s_axis_tready is high only while no request is in progress.
// A stalled result holds in the output register and stalls the sequencer.
// Reset is asynchronous; the trail and velocity memories are not cleared.
module bouncing_polygon_trail_step #(
    parameter int MAX_POLYS  = bpt_pkg::MAX_POLYS_DEF,
    parameter int MAX_VERTS  = bpt_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRAIL  = bpt_pkg::MAX_TRAIL_DEF,
    parameter int COORD_BITS = bpt_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] polygon
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // vertex, draw_x, draw_y, erase_x, erase_y, color
    output logic [0:0]  m_axis_tuser,   // [0] erase_valid
    output logic        m_axis_tlast
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [4:0]  polys_reg;
    logic [5:0]  verts_reg;
    logic [6:0]  trail_reg;
    logic [7:0]  speed_reg;
    logic [8:0]  colors_reg;
    logic [31:0] seed_reg;

    bpt_pkg::cfg_t    cfg;
    bpt_pkg::result_t res;

    logic [16:0] ext_top;
    logic [15:0] w_ext, h_ext;
    logic [8:0]  spd_raw;
    logic [7:0]  spd;
    logic [15:0] sixth;
    logic [7:0]  lo;
    logic [6:0]  polys_w, verts_w;
    logic [8:0]  trail_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bpt_pkg::RST_SCREEN_WIDTH;
            height_reg <= bpt_pkg::RST_SCREEN_HEIGHT;
            polys_reg  <= bpt_pkg::RST_POLYGON_COUNT;
            verts_reg  <= bpt_pkg::RST_POINT_COUNT;
            trail_reg  <= bpt_pkg::RST_TRAIL_LENGTH;
            speed_reg  <= bpt_pkg::RST_MAX_SPEED;
            colors_reg <= bpt_pkg::RST_COLOR_COUNT;
            seed_reg   <= bpt_pkg::RST_RNG_SEED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpt_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data[12:0];
                bpt_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data[12:0];
                bpt_pkg::REG_POLYGON_COUNT: polys_reg  <= cfg_data[4:0];
                bpt_pkg::REG_POINT_COUNT:   verts_reg  <= cfg_data[5:0];
                bpt_pkg::REG_TRAIL_LENGTH:  trail_reg  <= cfg_data[6:0];
                bpt_pkg::REG_MAX_SPEED:     speed_reg  <= cfg_data[7:0];
                bpt_pkg::REG_COLOR_COUNT:   colors_reg <= cfg_data[8:0];
                bpt_pkg::REG_RNG_SEED:      seed_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp registers to the ranges the engine supports
    always_comb
    begin
        ext_top = 17'(2 ** COORD_BITS);
        w_ext   = 16'(({4'b0, width_reg} > ext_top) ? ext_top : {4'b0, width_reg});
        h_ext   = 16'(({4'b0, height_reg} > ext_top) ? ext_top : {4'b0, height_reg});
        spd_raw = {1'b0, speed_reg};
        if (spd_raw < 9'd1)
            spd = 8'd1;
        else if (spd_raw > 9'd128)
            spd = 8'd128;
        else
            spd = speed_reg;
        sixth = (16'(spd) * bpt_pkg::SIXTH_MUL) >> bpt_pkg::SIXTH_SHIFT;
        lo    = (sixth < 16'd1) ? 8'd1 : sixth[7:0];
        polys_w = {2'b00, polys_reg};
        verts_w = {1'b0, verts_reg};
        trail_w = {2'b00, trail_reg};

        cfg.width      = w_ext;
        cfg.height     = h_ext;
        cfg.x_top      = (w_ext <= 16'd1) ? 16'd0 : w_ext - 16'd1;
        cfg.y_top      = (h_ext <= 16'd1) ? 16'd0 : h_ext - 16'd1;
        if (polys_w < 7'd1)
            cfg.polys = 7'd1;
        else if (polys_w > 7'(MAX_POLYS))
            cfg.polys = 7'(MAX_POLYS);
        else
            cfg.polys = polys_w;
        if (verts_w < 7'd3)
            cfg.verts = 7'd3;
        else if (verts_w > 7'(MAX_VERTS))
            cfg.verts = 7'(MAX_VERTS);
        else
            cfg.verts = verts_w;
        cfg.slots      = ((trail_w > 9'(MAX_TRAIL)) ? 9'(MAX_TRAIL) : trail_w) + 9'd1;
        cfg.speed_lo   = lo;
        cfg.speed_span = spd - lo;
        if (colors_reg < 9'd2)
            cfg.colors = 9'd2;
        else if (colors_reg > 9'd256)
            cfg.colors = 9'd256;
        else
            cfg.colors = colors_reg;
        cfg.seed       = seed_reg;
    end

    bpt_core #(
        .MAX_POLYS  (MAX_POLYS),
        .MAX_VERTS  (MAX_VERTS),
        .MAX_TRAIL  (MAX_TRAIL),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_poly   (s_axis_tdata[3:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {3'b000, res.color, res.erase_y, res.erase_x,
                           res.draw_y, res.draw_x, res.vertex};
    assign m_axis_tuser = res.erase_valid;
    assign m_axis_tlast = res.last;

endmodule

// ===== design/bpt_check.sv =====
// Port-level checker for the bouncing polygon trail engine, bound to the
// top level. Depends on bpt_pkg and the top level's ports.
module bpt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // erase coordinates are zero unless flagged valid
    a_erase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[52:29] == 24'd0)
        else $error("erase coordinates set without erase flag");

    // a rebuild request keeps the block busy
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == bpt_pkg::MODE_BUILD
            || s_axis_tuser == bpt_pkg::MODE_RESEED)
            |=> !s_axis_tready)
        else $error("ready right after a rebuild request");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind bouncing_polygon_trail_step bpt_check u_bpt_check (.*);

// ===== test/bouncing_polygon_trail_step_chk.sv =====
// Checker for the bouncing polygon trail engine: mirrors the register writes,
// predicts every vertex result of each accepted request and compares.
// Depends on bpt_pkg for the result layout and the register and mode codes.
module bouncing_polygon_trail_step_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] polygon
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // vertex, draw_x, draw_y, erase_x, erase_y, color
    input  logic [0:0]  m_axis_tuser,   // [0] erase_valid
    input  logic        m_axis_tlast,
    output int          fails,
    output int          pending,
    output int          results_seen
);
    import bpt_pkg::*;

    localparam int NP = 16;
    localparam int NV = 32;
    localparam int NS = 65;

    int unsigned r_width, r_height, r_polys, r_points, r_trail, r_speed, r_colors;
    logic [31:0] r_seed;

    logic [31:0] rand_word;
    int          trail_x [NP][NS][NV];
    int          trail_y [NP][NS][NV];
    int          vel_x [NP][NV];
    int          vel_y [NP][NV];
    int unsigned ring_pos [NP];
    int unsigned ring_fill [NP];
    int unsigned hue [NP];
    bit          hue_up [NP];

    result_t expected_verts[$];

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int span(int unsigned r);
        return r > 4096 ? 4096 : int'(r);
    endfunction

    function automatic logic [31:0] shuffle();
        logic [31:0] x;
        x = rand_word;
        x ^= x << 13;
        x ^= x >> 17;
        x ^= x << 5;
        rand_word = (x == 0) ? XS_ZERO_FIX : x;
        return rand_word;
    endfunction

    function automatic int pick_upto(int top);
        logic [31:0] d;
        if (top <= 0)
            return 0;
        d = shuffle();
        return int'(d % (top + 1));
    endfunction

    function automatic int pick_speed();
        int hi, lo, a, b;
        hi = int'(clip(r_speed, 1, 128));
        lo = hi / 6;
        if (lo < 1)
            lo = 1;
        if (hi < lo)
            hi = lo;
        a = pick_upto(hi - lo);
        b = pick_upto(hi - lo);
        return lo + (a + b) / 2;
    endfunction

    function automatic int pick_velocity();
        int m;
        logic [31:0] d;
        m = pick_speed();
        d = shuffle();
        return d[0] ? m : -m;
    endfunction

    function automatic int bounce(int pos, inout int vel, input int lim);
        int n;
        if (lim <= 1)
        begin
            vel = 0;
            return 0;
        end
        n = pos + vel;
        if (n < 0)
        begin
            n = -n;
            vel = pick_speed();
        end
        else if (n >= lim)
        begin
            n = (lim - 1) * 2 - n;
            vel = -pick_speed();
        end
        if (n < 0)
            n = 0;
        if (n > lim - 1)
            n = lim - 1;
        return n;
    endfunction

    function automatic void rebuild_all();
        int unsigned np, nv, ns, nc;
        int w, h;
        np = clip(r_polys, 1, 16);
        nv = clip(r_points, 3, 32);
        ns = clip(r_trail, 0, 64) + 1;
        nc = clip(r_colors, 2, 256);
        w = span(r_width);
        h = span(r_height);
        for (int p = 0; p < np; p++)
        begin
            ring_pos[p] = 0;
            ring_fill[p] = 1;
            hue[p] = (p * nc) / np;
            hue_up[p] = bit'(p & 1);
            for (int v = 0; v < nv; v++)
            begin
                trail_x[p][0][v] = pick_upto(w - 1);
                trail_y[p][0][v] = pick_upto(h - 1);
                vel_x[p][v] = pick_velocity();
                vel_y[p][v] = pick_velocity();
                for (int s = 1; s < ns; s++)
                begin
                    trail_x[p][s][v] = trail_x[p][0][v];
                    trail_y[p][s][v] = trail_y[p][0][v];
                end
            end
        end
    endfunction

    function automatic void advance_polygon(int p);
        int unsigned nv, ns, nc, cur, nxt;
        int w, h, col, nx, ny;
        bit erase;
        result_t r;
        nv = clip(r_points, 3, 32);
        ns = clip(r_trail, 0, 64) + 1;
        nc = clip(r_colors, 2, 256);
        w = span(r_width);
        h = span(r_height);
        cur = ring_pos[p] % ns;
        nxt = (cur + 1) % ns;
        erase = ring_fill[p] >= ns;
        col = int'(hue[p]) + (hue_up[p] ? 1 : -1);
        if (col < 0)
            col = int'(nc) - 1;
        else if (col >= int'(nc))
            col = 0;
        hue[p] = unsigned'(col);
        for (int v = 0; v < nv; v++)
        begin
            r.erase_x = erase ? 12'(trail_x[p][nxt][v]) : 12'd0;
            r.erase_y = erase ? 12'(trail_y[p][nxt][v]) : 12'd0;
            nx = bounce(trail_x[p][cur][v], vel_x[p][v], w);
            ny = bounce(trail_y[p][cur][v], vel_y[p][v], h);
            trail_x[p][nxt][v] = nx;
            trail_y[p][nxt][v] = ny;
            r.vertex = 5'(v);
            r.draw_x = 12'(nx);
            r.draw_y = 12'(ny);
            r.erase_valid = erase;
            r.color = 8'(col);
            r.last = (v == nv - 1);
            expected_verts.push_back(r);
        end
        ring_pos[p] = nxt;
        ring_fill[p] = ring_fill[p] < ns ? ring_fill[p] + 1 : ns;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        results_seen = 0;
    end

    assign pending = expected_verts.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_width = RST_SCREEN_WIDTH;
            r_height = RST_SCREEN_HEIGHT;
            r_polys = RST_POLYGON_COUNT;
            r_points = RST_POINT_COUNT;
            r_trail = RST_TRAIL_LENGTH;
            r_speed = RST_MAX_SPEED;
            r_colors = RST_COLOR_COUNT;
            r_seed = RST_RNG_SEED;
            rand_word = 1;
            for (int p = 0; p < NP; p++)
            begin
                ring_pos[p] = 0;
                ring_fill[p] = 1;
                hue[p] = 0;
                hue_up[p] = 0;
            end
            expected_verts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  r_width = cfg_data[12:0];
                    REG_SCREEN_HEIGHT: r_height = cfg_data[12:0];
                    REG_POLYGON_COUNT: r_polys = cfg_data[4:0];
                    REG_POINT_COUNT:   r_points = cfg_data[5:0];
                    REG_TRAIL_LENGTH:  r_trail = cfg_data[6:0];
                    REG_MAX_SPEED:     r_speed = cfg_data[7:0];
                    REG_COLOR_COUNT:   r_colors = cfg_data[8:0];
                    REG_RNG_SEED:      r_seed = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == MODE_RESEED)
                    rand_word = (r_seed != 0) ? r_seed : 32'd1;
                if (s_axis_tuser == MODE_BUILD || s_axis_tuser == MODE_RESEED)
                    rebuild_all();
                else if (s_axis_tuser == MODE_STEP && s_axis_tdata[3:0] < clip(r_polys, 1, 16))
                    advance_polygon(int'(s_axis_tdata[3:0]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verts.size() == 0)
                begin
                    report("unexpected result, vertex", int'(m_axis_tdata[4:0]), -1);
                end
                else
                begin
                    result_t e;
                    e = expected_verts.pop_front();
                    if (m_axis_tdata[4:0] != e.vertex)
                        report("vertex", int'(m_axis_tdata[4:0]), int'(e.vertex));
                    if (m_axis_tdata[16:5] != e.draw_x)
                        report("draw_x", int'(m_axis_tdata[16:5]), int'(e.draw_x));
                    if (m_axis_tdata[28:17] != e.draw_y)
                        report("draw_y", int'(m_axis_tdata[28:17]), int'(e.draw_y));
                    if (m_axis_tuser[0] != e.erase_valid)
                        report("erase_valid", int'(m_axis_tuser[0]), int'(e.erase_valid));
                    if (m_axis_tdata[40:29] != e.erase_x)
                        report("erase_x", int'(m_axis_tdata[40:29]), int'(e.erase_x));
                    if (m_axis_tdata[52:41] != e.erase_y)
                        report("erase_y", int'(m_axis_tdata[52:41]), int'(e.erase_y));
                    if (m_axis_tdata[60:53] != e.color)
                        report("color", int'(m_axis_tdata[60:53]), int'(e.color));
                    if (m_axis_tlast != e.last)
                        report("last", int'(m_axis_tlast), int'(e.last));
                end
                results_seen++;
            end
        end
    end

endmodule

// ===== test/bouncing_polygon_trail_step_tb.sv =====
// Stimulus and verdict for the bouncing polygon trail engine: register
// phases, step and rebuild requests, bursty sender and stalling receiver.
// Depends on bpt_pkg, the block and bouncing_polygon_trail_step_chk.
module bouncing_polygon_trail_step_tb;
    import bpt_pkg::*;

    localparam int IDLE_LIMIT = 500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fails, pending, results_seen;
    int requests_sent, burst_left, phases_run;
    int idle_cycles;
    int seg_left, seg_kind, seg_count;
    int unsigned cur_polys;

    bouncing_polygon_trail_step i_dut (.*);

    bouncing_polygon_trail_step_chk i_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: segments of full flow, random stalls, or a long hold-off
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_count++;
            seg_kind = (seg_count == 4 || $urandom_range(0, 7) == 0) ? 2 : $urandom_range(0, 1);
            seg_left = (seg_kind == 2) ? 400 : $urandom_range(40, 300);
        end
        seg_left--;
        case (seg_kind)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 2) != 0;
            default: m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(input logic [1:0] mode, input logic [3:0] poly);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, poly};
        s_axis_tuser <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // hold input until every result is back and the block takes requests again
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (!(pending == 0 && s_axis_tready))
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_polys = vals[REG_POLYGON_COUNT][4:0] == 0 ? 1 :
                    (vals[REG_POLYGON_COUNT][4:0] > 16 ? 16 : vals[REG_POLYGON_COUNT][4:0]);
        phases_run++;
    endtask

    task automatic write_one(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly steps of polygons in use, some out of range, rare rebuilds
    task automatic random_steps(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 39);
            if (k == 0)
                send(MODE_BUILD, 4'($urandom_range(0, 15)));
            else if (k == 1)
                send(MODE_RESEED, 4'($urandom_range(0, 15)));
            else if (k == 2)
                send(MODE_NONE, 4'($urandom_range(0, 15)));
            else if (k < 6)
                send(MODE_STEP, 4'($urandom_range(0, 15)));
            else
                send(MODE_STEP, 4'($urandom_range(0, cur_polys - 1)));
        end
    endtask

    initial
    begin
        logic [31:0] v [8];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        seg_left = 0;
        seg_kind = 0;
        seg_count = 0;
        idle_cycles = 0;
        requests_sent = 0;
        burst_left = 0;
        phases_run = 0;
        cur_polys = 2;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, unused polygon, ignored mode, reseed
        send(MODE_BUILD, 4'hF);
        send(MODE_STEP, 4'd0);
        send(MODE_STEP, 4'd1);
        send(MODE_STEP, 4'd2);
        send(MODE_STEP, 4'd15);
        send(MODE_NONE, 4'hA);
        send(MODE_NONE, 4'h5);
        send(MODE_RESEED, 4'h0);
        for (int i = 0; i < 6; i++)
            send(MODE_STEP, {3'b000, i[0]});
        drain();

        // tiny x axis, clipped height, zero seed, two colors, top speed
        v = '{32'd1, 32'd8191, 32'd16, 32'd3, 32'd0, 32'd255, 32'd2, 32'd0};
        write_regs(v);
        send(MODE_RESEED, 4'd0);
        for (int i = 0; i < 16; i++)
            send(MODE_STEP, i[3:0]);
        drain();

        // zero height, one long polygon, full trail, slowest speed
        v = '{32'd4096, 32'd0, 32'd0, 32'd32, 32'd64, 32'd1, 32'd256, 32'hFFFF_FFFF};
        write_regs(v);
        send(MODE_RESEED, 4'd0);
        for (int i = 0; i < 70; i++)
            send(MODE_STEP, i == 20 ? 4'd1 : 4'd0);
        drain();

        // polygon, point, trail and color registers past their saturation points, top speed
        v = '{32'd30, 32'd20, 32'd31, 32'd63, 32'd127, 32'd128, 32'd511, $urandom};
        write_regs(v);
        send(MODE_RESEED, 4'd0);
        random_steps(12);
        drain();

        // shrink trail, points, polygons and screen after a rebuild
        v = '{32'd200, 32'd150, 32'd6, 32'd8, 32'd9, 32'd40, 32'd9, $urandom};
        write_regs(v);
        send(MODE_RESEED, 4'd0);
        random_steps(20);
        drain();
        write_one(REG_TRAIL_LENGTH, 32'd3);
        write_one(REG_POINT_COUNT, 32'd5);
        write_one(REG_POLYGON_COUNT, 32'd4);
        write_one(REG_SCREEN_WIDTH, 32'd17);
        write_one(REG_SCREEN_HEIGHT, 32'd9);
        cur_polys = 4;
        for (int i = 0; i < 20; i++)
            send(MODE_STEP, 4'($urandom_range(0, 3)));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            v[REG_SCREEN_WIDTH] = $urandom_range(0, 5) == 0 ? $urandom_range(0, 8191)
                                                            : $urandom_range(2, 64);
            v[REG_SCREEN_HEIGHT] = $urandom_range(0, 5) == 0 ? $urandom_range(0, 8191)
                                                             : $urandom_range(2, 64);
            v[REG_POLYGON_COUNT] = $urandom_range(1, 4);
            v[REG_POINT_COUNT] = $urandom_range(3, 8);
            v[REG_TRAIL_LENGTH] = $urandom_range(0, 12);
            v[REG_MAX_SPEED] = $urandom_range(0, 255);
            v[REG_COLOR_COUNT] = $urandom_range(0, 511);
            v[REG_RNG_SEED] = $urandom;
            write_regs(v);
            send(ph[0] ? MODE_BUILD : MODE_RESEED, 4'($urandom_range(0, 15)));
            random_steps(16);
            if (ph == 2)
                drain();
            random_steps(8);
            drain();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d requests over %0d register settings, %0d vertex results",
                 requests_sent, phases_run, results_seen);
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
